FILE: rtl/lbf_pkg.sv
package lbf_pkg;

  // Bank geometry.
  localparam int NUM_BANKS   = 16;
  localparam int LANES       = 8;
  localparam int NUM_LIGHTS  = NUM_BANKS * LANES;
  localparam int BANK_W      = $clog2(NUM_BANKS);
  localparam int LANE_W      = $clog2(LANES);
  localparam int MODE_W      = 2;
  localparam int ROW_W       = LANES * MODE_W;
  localparam int PAT_W       = 8;

  // Payload field widths.
  localparam int LIGHT_W     = 7;
  localparam int BANK_NUM_W  = 4;

  // Configuration register widths and reset values.
  localparam int PERIOD_W    = 16;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd250;

  // Register indexes (byte address is four times the index).
  localparam logic REG_FLASH_PERIOD = 1'b0;
  localparam logic REG_UPPER_MASK   = 1'b1;

  // Output mask when the upper bank bits are suppressed.
  localparam logic [PAT_W-1:0] UPPER_MASK = 8'b0011_1111;

  // Flash step.
  localparam int PHASE_COUNT = 4;
  localparam int PHASE_W     = $clog2(PHASE_COUNT);

  // Command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Request kinds.
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Light modes.
  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SLOW = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FAST = 2'd3;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic               refresh;  // rebuild all banks, then drive them
    logic               store;    // set request whose light exists
    logic [LIGHT_W-1:0] light;
    logic [MODE_W-1:0]  mode;
  } cmd_t;

  // Whether a light in the given mode is lit in the given flash phase.
  function automatic logic lbf_lit(input logic [MODE_W-1:0] m,
                                   input logic [PHASE_W-1:0] phase);
    logic res;
    case (m)
      MODE_ON:   res = 1'b1;
      MODE_SLOW: res = (phase < PHASE_W'(2));
      MODE_FAST: res = ~phase[0];
      default:   res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/lbf_front.sv
module lbf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [lbf_pkg::LIGHT_W-1:0]  in_light_index,
  input  logic [lbf_pkg::MODE_W-1:0]   in_mode,
  input  logic [lbf_pkg::PERIOD_W-1:0] period,
  output logic                         cmd_valid,
  output lbf_pkg::cmd_t                cmd,
  input  logic                         cmd_pop
);
  import lbf_pkg::*;

  logic [PERIOD_W-1:0] ms_count_r, ms_count_nxt;
  logic [PERIOD_W-1:0] tick_sum;
  logic                accept, reach, push;
  cmd_t                entry;

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r;

  // Accept a request whenever the queue has room.
  assign in_stall = (q_cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign accept   = in_valid & ~in_stall;

  // Millisecond counting: a tick that reaches the period becomes a refresh.
  assign tick_sum = ms_count_r + PERIOD_W'(1);
  assign reach    = (tick_sum >= period);

  always_comb begin
    ms_count_nxt = ms_count_r;
    if (accept && in_kind == KIND_TICK) begin
      ms_count_nxt = reach ? '0 : tick_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_count_r <= '0;
    end else begin
      ms_count_r <= ms_count_nxt;
    end
  end

  // Classify the request into a queue entry.
  always_comb begin
    entry.refresh = (in_kind == KIND_TICK);
    entry.store   = (in_kind == KIND_SET) &&
                    ({1'b0, in_light_index} < (LIGHT_W + 1)'(NUM_LIGHTS));
    entry.light   = in_light_index;
    entry.mode    = in_mode;
  end

  assign push = accept & ((in_kind == KIND_SET) | reach);

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !cmd_pop) begin
        q_cnt_r <= q_cnt_r + 1'b1;
      end else if (!push && cmd_pop) begin
        q_cnt_r <= q_cnt_r - 1'b1;
      end
    end
  end

  assign cmd_valid = (q_cnt_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];

endmodule

FILE: rtl/lbf_back.sv
module lbf_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  input  lbf_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  input  logic                           upper_masked,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lbf_pkg::BANK_NUM_W-1:0] out_bank_number,
  output logic [lbf_pkg::PAT_W-1:0]      out_drive_pattern,
  output logic                           out_last
);
  import lbf_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_REBUILD = 2'd1;
  localparam logic [1:0] ST_DRIVE   = 2'd2;

  logic [1:0]         state_r;
  logic [BANK_W:0]    cnt_r;
  logic [PHASE_W-1:0] phase_r;
  logic [PAT_W-1:0]   bank_r [NUM_BANKS];

  // Mode memory: one row of eight 2-bit modes per bank, with a valid bit per row.
  logic [ROW_W-1:0]     mode_mem [NUM_BANKS];
  logic [NUM_BANKS-1:0] row_vld_r;
  logic [ROW_W-1:0]     rd_row_r;
  logic                 rd_vld_r;

  logic [BANK_W-1:0]  set_row;
  logic [LANE_W-1:0]  set_lane;
  logic               set_go;
  logic [BANK_W-1:0]  cnt_idx, prev_idx;
  logic               rd_go, out_load;
  logic [PAT_W-1:0]   rebuilt, out_mask;

  logic                  out_valid_r;
  logic [BANK_NUM_W-1:0] out_bank_number_r;
  logic [PAT_W-1:0]      out_drive_pattern_r;
  logic                  out_last_r;

  assign cmd_pop  = (state_r == ST_IDLE) & cmd_valid;
  assign set_go   = cmd_pop & ~cmd.refresh & cmd.store;
  assign set_row  = BANK_W'(cmd.light >> LANE_W);
  assign set_lane = cmd.light[LANE_W-1:0];
  assign cnt_idx  = cnt_r[BANK_W-1:0];
  assign prev_idx = BANK_W'(cnt_r - 1'b1);
  assign rd_go    = (state_r == ST_REBUILD) && (cnt_r < (BANK_W + 1)'(NUM_BANKS));
  assign out_load = (state_r == ST_DRIVE) && (!out_valid_r || !out_stall);
  assign out_mask = upper_masked ? UPPER_MASK : '1;

  // A set writes its lane; a row never written before gets its other lanes cleared.
  always_ff @(posedge clk) begin
    if (set_go) begin
      for (int k = 0; k < LANES; k++) begin
        if (LANE_W'(k) == set_lane) begin
          mode_mem[set_row][k*MODE_W +: MODE_W] <= cmd.mode;
        end else if (!row_vld_r[set_row]) begin
          mode_mem[set_row][k*MODE_W +: MODE_W] <= MODE_OFF;
        end
      end
    end
    if (rd_go) begin
      rd_row_r <= mode_mem[cnt_idx];
      rd_vld_r <= row_vld_r[cnt_idx];
    end
  end

  // Bank pattern rebuilt from the row read in the previous cycle.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rebuilt[k] = rd_vld_r & lbf_lit(rd_row_r[k*MODE_W +: MODE_W], phase_r);
    end
  end

  // Sequencer: apply a set or rebuild all banks, then drive every bank in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      phase_r   <= '0;
      row_vld_r <= '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
        bank_r[b] <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            cnt_r <= '0;
            if (cmd.refresh) begin
              state_r <= ST_REBUILD;
            end else begin
              state_r <= ST_DRIVE;
              if (cmd.store) begin
                row_vld_r[set_row]         <= 1'b1;
                bank_r[set_row][set_lane] <= (cmd.mode != MODE_OFF);
              end
            end
          end
        end
        ST_REBUILD: begin
          if (cnt_r != '0) begin
            bank_r[prev_idx] <= rebuilt;
          end
          if (cnt_r == (BANK_W + 1)'(NUM_BANKS)) begin
            state_r <= ST_DRIVE;
            cnt_r   <= '0;
            phase_r <= phase_r + 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DRIVE: begin
          if (out_load) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_idx == BANK_W'(NUM_BANKS - 1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload: inverted and optionally masked bank bits.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bank_number_r   <= BANK_NUM_W'(cnt_idx);
      out_drive_pattern_r <= ~(bank_r[cnt_idx] & out_mask);
      out_last_r          <= (cnt_idx == BANK_W'(NUM_BANKS - 1));
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bank_number   = out_bank_number_r;
  assign out_drive_pattern = out_drive_pattern_r;
  assign out_last          = out_last_r;

endmodule

FILE: rtl/led_bank_flash_controller_core.sv
// LED bank flash controller. Holds a mode (off, on, slow flash, fast flash) for each of
// 128 lights and an 8-bit pattern for each of 16 banks. A set request stores one light's
// mode, updates its bank bit and then drives all 16 banks; a tick request counts one
// millisecond, and when the count reaches flash_period_ms every bank is rebuilt from the
// modes and the 4-phase flash step before all banks are driven. Each drive run produces
// 16 output words, bank 0 first, with inverted bits (0 lights an LED) and last set on bank
// 15. Flow: a tick below the period is absorbed by the front and produces nothing. A set
// request is applied when the back takes the command, then the 16 output words follow. A
// refresh takes the command, reads the 16 mode-memory rows one per cycle and writes the
// last bank, then drives the 16 output words. A two-entry request queue lets requests be
// taken while a drive run is still in progress. Registers sit at byte addresses 0
// (flash_period_ms) and 4 (upper_bits_masked); pready is always high.
module led_bank_flash_controller_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [lbf_pkg::LIGHT_W-1:0]    in_light_index,
  input  logic [lbf_pkg::MODE_W-1:0]     in_mode,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lbf_pkg::BANK_NUM_W-1:0] out_bank_number,
  output logic [lbf_pkg::PAT_W-1:0]      out_drive_pattern,
  output logic                           out_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbf_pkg::ADDR_W-1:0]     paddr,
  input  logic [lbf_pkg::DATA_W-1:0]     pwdata,
  output logic [lbf_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import lbf_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic                upper_masked_r;
  logic                cfg_wr;
  logic                reg_idx;
  logic                cmd_valid, cmd_pop;
  cmd_t                cmd;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r       <= PERIOD_RESET;
      upper_masked_r <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FLASH_PERIOD: period_r       <= pwdata[PERIOD_W-1:0];
        REG_UPPER_MASK:   upper_masked_r <= pwdata[0];
        default:          period_r       <= period_r;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_FLASH_PERIOD: prdata = DATA_W'(period_r);
      REG_UPPER_MASK:   prdata = DATA_W'(upper_masked_r);
      default:          prdata = '0;
    endcase
  end

  // Front: accepts requests, counts ticks, queues set and refresh commands.
  lbf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_light_index (in_light_index),
    .in_mode        (in_mode),
    .period         (period_r),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Back: applies commands, rebuilds banks and drives the output words.
  lbf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .upper_masked      (upper_masked_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bank_number   (out_bank_number),
    .out_drive_pattern (out_drive_pattern),
    .out_last          (out_last)
  );

endmodule

FILE: rtl/lbf_checker.sv
module lbf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lbf_pkg::BANK_NUM_W-1:0] out_bank_number,
  input logic [lbf_pkg::PAT_W-1:0]      out_drive_pattern,
  input logic                           out_last
);
  import lbf_pkg::*;

  // The last flag marks exactly the final bank.
  a_last_bank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_bank_number == BANK_NUM_W'(NUM_BANKS - 1))))
    else $error("last flag does not match the final bank");

  // Within a run the next bank follows immediately.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_bank_number == $past(out_bank_number) + 1'b1))
    else $error("drive run broke or skipped a bank");

  // After the final bank, any word that follows at once starts a new run at bank 0.
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid || (out_bank_number == '0))
    else $error("new drive run does not start at bank 0");

  // A stalled output word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_bank_number) && $stable(out_drive_pattern))
    else $error("stalled output word changed");

endmodule

bind led_bank_flash_controller_core lbf_checker u_lbf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_bank_number   (out_bank_number),
  .out_drive_pattern (out_drive_pattern),
  .out_last          (out_last)
);
